// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int PRIO_W = 8;
  localparam int AGE_W  = 8;
  localparam int ID_W   = 31;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [AGE_W-1:0]  patient_age;
    logic [ID_W-1:0]   patient_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] out_priority;
    logic [AGE_W-1:0]  out_age;
    logic [ID_W-1:0]   out_id;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [AGE_W-1:0]  age;
    logic [ID_W-1:0]   id;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t fresh;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  entry_t     left_entry,
  input  logic       left_le,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       le
);

  entry_t entry_next;

  // held entry goes ahead of (or ties with) the new one
  assign le = occupied && (entry.prio <= ctrl.fresh.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (!le) begin
        entry_next = left_le ? ctrl.fresh : left_entry;
      end
    end else if (ctrl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// stable_priority_queue: bounded sorted priority queue, smallest priority first.
// A request is taken at a rising edge where start is high and busy is low.
// req.req_type selects insert (0) or remove (1); insert carries priority,
// age and id. Equal priorities leave in arrival order.
// Every transaction produces exactly one result, shown on result for a single
// cycle with done high, in the cycle after the request is taken. result.status
// is ok, empty (remove with nothing held) or full (insert rejected), and
// result.occupancy gives the count after the request, low five bits.
// Throughput is one request per cycle: the row of cells compares every held
// entry against the new one in parallel and shifts in one step, so busy stays
// low outside reset.
// Reset empties the queue and holds busy high until the cycle after release.
// There is no stall on the result side: a result not taken in its cycle is
// gone, and the caller must be ready for it.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  cell_ctrl_t       ctrl;
  result_t          result_next;

  entry_t entries [QUEUE_DEPTH];
  logic   le_vec  [QUEUE_DEPTH];

  assign accept   = start && !busy;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  assign ctrl.ins   = accept && (req.req_type == REQ_INSERT) && !is_full;
  assign ctrl.rem   = accept && (req.req_type == REQ_REMOVE) && !is_empty;
  assign ctrl.fresh = '{prio: req.priority_req, age: req.patient_age, id: req.patient_id};

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
      entry_t left_e;
      logic   left_l;
      entry_t right_e;

      if (gi == 0) begin : g_head
        assign left_e = ctrl.fresh;
        assign left_l = 1'b1;
      end else begin : g_body
        assign left_e = entries[gi-1];
        assign left_l = le_vec[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_e = entries[gi];
      end else begin : g_inner
        assign right_e = entries[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (IDX < count),
        .left_entry  (left_e),
        .left_le     (left_l),
        .right_entry (right_e),
        .entry       (entries[gi]),
        .le          (le_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    result_next              = '0;
    result_next.occupancy    = OCC_W'(count_next);
    if (req.req_type == REQ_INSERT) begin
      result_next.status = is_full ? STATUS_FULL : STATUS_OK;
    end else if (is_empty) begin
      result_next.status = STATUS_EMPTY;
    end else begin
      result_next.status       = STATUS_OK;
      result_next.out_priority = entries[0].prio;
      result_next.out_age      = entries[0].age;
      result_next.out_id       = entries[0].id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result strobe missing after a taken request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond queue depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_INSERT && is_full) |=> (count == $past(count)))
    else $error("rejected insert changed the count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_EMPTY) |-> (result.occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule

// ===== tb/spq_checker.sv =====
`timescale 1ns / 100ps

module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        done,
  input  result_t     result,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned stored,
  output int unsigned rejected,
  output int unsigned served,
  output int unsigned empty_pops
);

  entry_t      held[QUEUE_DEPTH];
  int          held_count = 0;
  result_t     due_results[$];
  int unsigned err_count = 0;
  int unsigned n_stored = 0;
  int unsigned n_rejected = 0;
  int unsigned n_served = 0;
  int unsigned n_empty = 0;

  // applies one request to the shadow queue and returns the result it must produce
  function automatic result_t serve_request(req_t r);
    result_t res;
    entry_t  fresh;
    int      pos;
    res = '0;
    if (r.req_type == REQ_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
        n_rejected++;
      end else begin
        fresh.prio = r.priority_req;
        fresh.age  = r.patient_age;
        fresh.id   = r.patient_id;
        // slide larger priorities up; equal ones stay ahead of the new entry
        pos = held_count;
        while (pos > 0 && held[pos-1].prio > fresh.prio) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = fresh;
        held_count++;
        res.status = STATUS_OK;
        n_stored++;
      end
    end else if (held_count == 0) begin
      res.status = STATUS_EMPTY;
      n_empty++;
    end else begin
      res.status       = STATUS_OK;
      res.out_priority = held[0].prio;
      res.out_age      = held[0].age;
      res.out_id       = held[0].id;
      for (int k = 1; k < held_count; k++) held[k-1] = held[k];
      held_count--;
      n_served++;
    end
    res.occupancy = OCC_W'(held_count);
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t mismatch on %s: got %0h want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (due_results.size() == 0) begin
          note_mismatch("result with no transaction waiting", 32'(result), 0);
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status)
            note_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.out_priority !== want.out_priority)
            note_mismatch("out_priority", 32'(result.out_priority), 32'(want.out_priority));
          if (result.out_age !== want.out_age)
            note_mismatch("out_age", 32'(result.out_age), 32'(want.out_age));
          if (result.out_id !== want.out_id)
            note_mismatch("out_id", 32'(result.out_id), 32'(want.out_id));
          if (result.occupancy !== want.occupancy)
            note_mismatch("occupancy", 32'(result.occupancy), 32'(want.occupancy));
        end
      end
      if (start === 1'b1 && busy === 1'b0) due_results.push_back(serve_request(req));
    end
    errors     <= err_count;
    pending    <= due_results.size();
    stored     <= n_stored;
    rejected   <= n_rejected;
    served     <= n_served;
    empty_pops <= n_empty;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
  localparam int ITEM_TOTAL  = 1350;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  req_t    req = '0;
  logic    busy;
  logic    done;
  result_t result;

  int unsigned errors, pending, stored, rejected, served, empty_pops;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .result     (result),
    .errors     (errors),
    .pending    (pending),
    .stored     (stored),
    .rejected   (rejected),
    .served     (served),
    .empty_pops (empty_pops)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic req_t make_req(logic kind, logic [PRIO_W-1:0] prio,
                                    logic [AGE_W-1:0] age, logic [ID_W-1:0] id);
    req_t r;
    r.req_type     = kind;
    r.priority_req = prio;
    r.patient_age  = age;
    r.patient_id   = id;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit idle_on);
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio(int prio_mode);
    case (prio_mode)
      0: return PRIO_W'($urandom_range(0, 3));
      1: return PRIO_W'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return PRIO_W'($urandom_range(1, 2));
          default: return PRIO_W'($urandom_range(253, 254));
        endcase
      end
    endcase
  endfunction

  // holds start until the transaction is taken, then, if gap is nonzero, drops start and idles
  task automatic issue(req_t item, int gap);
    req   <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int          sent;
    int          phase_len;
    int          prio_mode;
    int          ins_pct;
    bit          idle_on;
    logic        kind;
    phase_kind_t phase;

    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, extremes, equal priorities, then drain in order
    issue(make_req(REQ_REMOVE, '1, '1, '1), 0);
    issue(make_req(REQ_INSERT, 8'd128, 8'd0, 31'h0), 0);
    issue(make_req(REQ_INSERT, 8'd255, 8'd255, 31'h7FFF_FFFF), 1);
    issue(make_req(REQ_INSERT, 8'd0, 8'd255, 31'h5555_5555), 0);
    issue(make_req(REQ_INSERT, 8'd128, 8'd1, 31'h2AAA_AAAA), 2);
    issue(make_req(REQ_INSERT, 8'd0, 8'd0, 31'h1), 0);
    issue(make_req(REQ_INSERT, 8'd128, 8'd170, 31'h3), 0);
    repeat (6) issue(make_req(REQ_REMOVE, 8'($urandom()), 8'($urandom()),
                              31'($urandom())), pick_gap(1));
    issue(make_req(REQ_REMOVE, '0, '0, '0), 0);
    sent = 14;

    phase = PHASE_FILL;
    while (sent < ITEM_TOTAL) begin
      phase_len = $urandom_range(10, 60);
      prio_mode = $urandom_range(0, 2);
      idle_on   = ($urandom_range(0, 3) != 0);
      case (phase)
        PHASE_FILL:  ins_pct = 85;
        PHASE_DRAIN: ins_pct = 15;
        default:     ins_pct = 50;
      endcase
      for (int i = 0; i < phase_len && sent < ITEM_TOTAL; i++) begin
        kind = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
        issue(make_req(kind, pick_prio(prio_mode), 8'($urandom()), 31'($urandom())),
              pick_gap(idle_on));
        sent++;
      end
      phase = phase_kind_t'($urandom_range(0, 2));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d transactions: %0d inserts stored, %0d rejected as full",
             sent, stored, rejected);
    $display("%0d removes served in priority order, %0d removes on an empty queue",
             served, empty_pops);
    if (errors == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/spq_checker.sv
tb/tb_top.sv
